// ----- hw/rtl/vdl_pkg.sv -----
// Shared types and constants of the vector display-list executor.
// No dependencies; imported by every module of the block.
package vdl_pkg;

  localparam int ADDR_W      = 13;
  localparam int STACK_DEPTH = 4;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_W       = 10;

  localparam logic [3:0] OP_LONG_LAST = 4'h9;
  localparam logic [3:0] OP_POSITION  = 4'ha;
  localparam logic [3:0] OP_HALT      = 4'hb;
  localparam logic [3:0] OP_CALL      = 4'hc;
  localparam logic [3:0] OP_RETURN    = 4'hd;
  localparam logic [3:0] OP_JUMP      = 4'he;
  localparam logic [3:0] OP_SHORT     = 4'hf;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_EXEC  = 1'b1;

  localparam logic REG_X_MIN = 1'b0;
  localparam logic REG_Y_MAX = 1'b1;

  localparam logic [3:0] SHIFT_CODE_LAST = 4'd9;

  typedef enum logic [2:0] {
    K_VECTOR,
    K_POSITION,
    K_HALT,
    K_CALL,
    K_RETURN,
    K_JUMP
  } kind_t;

  typedef struct packed {
    logic              start;
    kind_t             kind;
    logic              wide;
    logic [3:0]        inten;
    logic [9:0]        mx;
    logic              nx;
    logic [9:0]        my;
    logic              ny;
    logic [3:0]        code_add;
    logic [ADDR_W-1:0] target;
    logic [11:0]       pos_x;
    logic [11:0]       pos_y;
    logic [3:0]        scale;
  } item_t;

endpackage

// ----- hw/rtl/vdl_front.sv -----
// Front end: accepts input items and decodes them into execution records.
// Depends on vdl_pkg.
module vdl_front import vdl_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [15:0] first_word,
  input  logic [15:0] second_word,
  output logic        dec_valid,
  input  logic        dec_ready,
  output item_t       dec_item
);

  logic [3:0] op;

  assign op        = first_word[15:12];
  assign in_ready  = dec_ready;
  assign dec_valid = in_valid;

  always_comb begin
    dec_item          = '0;
    dec_item.start    = (command == CMD_START);
    dec_item.target   = {first_word[11:0], 1'b0};
    dec_item.pos_x    = second_word[11:0];
    dec_item.pos_y    = first_word[11:0];
    dec_item.scale    = second_word[15:12];
    dec_item.my       = first_word[9:0];
    dec_item.ny       = first_word[10];
    dec_item.mx       = second_word[9:0];
    dec_item.nx       = second_word[10];
    dec_item.inten    = second_word[15:12];
    dec_item.code_add = op;
    if (op <= OP_LONG_LAST) begin
      dec_item.kind = K_VECTOR;
      dec_item.wide = 1'b1;
    end else begin
      case (op)
        OP_POSITION: begin
          dec_item.kind = K_POSITION;
          dec_item.wide = 1'b1;
        end
        OP_HALT:   dec_item.kind = K_HALT;
        OP_CALL:   dec_item.kind = K_CALL;
        OP_RETURN: dec_item.kind = K_RETURN;
        OP_JUMP:   dec_item.kind = K_JUMP;
        OP_SHORT: begin
          dec_item.kind     = K_VECTOR;
          dec_item.inten    = first_word[7:4];
          dec_item.my       = {first_word[9:8], 8'd0};
          dec_item.mx       = {first_word[1:0], 8'd0};
          dec_item.nx       = first_word[2];
          dec_item.code_add = 4'd2 + {2'b00, first_word[3], 1'b0}
                              + {3'b000, first_word[11]};
        end
        default: dec_item.kind = K_HALT;
      endcase
    end
  end

endmodule

// ----- hw/rtl/vdl_queue.sv -----
// Short queue of decoded items between the front end and the execution unit.
// Depends on vdl_pkg.
module vdl_queue import vdl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_item
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign wr_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/vdl_back.sv -----
// Execution unit: program address, return stack, scale, beam, config, result register.
// Depends on vdl_pkg.
module vdl_back import vdl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  item_t                   q_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ADDR_W-1:0]       next_address,
  output logic                    draw,
  output logic signed [15:0]      start_x,
  output logic signed [15:0]      start_y,
  output logic signed [15:0]      end_x,
  output logic signed [15:0]      end_y,
  output logic [3:0]              intensity,
  output logic                    halted
);

  logic [CFG_W-1:0]  x_min;
  logic [CFG_W-1:0]  y_max;
  logic [ADDR_W-1:0] pc;
  logic [ADDR_W-1:0] pc_next;
  logic [ADDR_W-1:0] stack [STACK_DEPTH];
  logic [LVL_W-1:0]  level;
  logic [LVL_W-1:0]  level_next;
  logic [LVL_W-1:0]  level_dec;
  logic [3:0]        scale;
  logic [3:0]        scale_next;
  logic [31:0]       beam_x;
  logic [31:0]       beam_x_next;
  logic [31:0]       beam_y;
  logic [31:0]       beam_y_next;
  logic              halt;
  logic              halt_next;
  logic              draw_next;
  logic [3:0]        inten_next;
  logic [15:0]       sx_next;
  logic [15:0]       sy_next;
  logic              take;
  logic              push;
  logic              full;
  logic [ADDR_W-1:0] pc_step;
  logic [3:0]        code;
  logic [4:0]        shamt;
  logic [10:0]       sdx;
  logic [10:0]       sdy;
  logic [31:0]       dx;
  logic [31:0]       dy;
  logic [15:0]       pos_x;
  logic [15:0]       pos_y;

  assign take      = q_valid && (!out_valid || out_ready);
  assign q_ready   = take;
  assign full      = (level == LVL_W'(STACK_DEPTH));
  assign level_dec = level - 1'b1;
  assign code      = scale + q_item.code_add;
  assign shamt     = (code > SHIFT_CODE_LAST) ? 5'd6 : 5'd7 + {1'b0, code};
  assign sdx       = q_item.nx ? -{1'b0, q_item.mx} : {1'b0, q_item.mx};
  assign sdy       = q_item.ny ? -{1'b0, q_item.my} : {1'b0, q_item.my};
  assign dx        = {{21{sdx[10]}}, sdx} << shamt;
  assign dy        = {{21{sdy[10]}}, sdy} << shamt;
  assign pos_x     = {{4{q_item.pos_x[11]}}, q_item.pos_x} - {6'd0, x_min};
  assign pos_y     = {6'd0, y_max} - {{4{q_item.pos_y[11]}}, q_item.pos_y};
  assign pc_step   = pc + (q_item.wide ? ADDR_W'(4) : ADDR_W'(2));

  always_comb begin
    pc_next     = pc;
    level_next  = level;
    scale_next  = scale;
    beam_x_next = beam_x;
    beam_y_next = beam_y;
    halt_next   = halt;
    draw_next   = 1'b0;
    inten_next  = 4'd0;
    sx_next     = beam_x[31:16];
    sy_next     = beam_y[31:16];
    push        = 1'b0;
    if (q_item.start) begin
      pc_next     = '0;
      level_next  = '0;
      scale_next  = 4'd0;
      beam_x_next = '0;
      beam_y_next = '0;
      halt_next   = 1'b0;
      sx_next     = '0;
      sy_next     = '0;
    end else if (!halt) begin
      pc_next = pc_step;
      case (q_item.kind)
        K_VECTOR: begin
          beam_x_next = beam_x + dx;
          beam_y_next = beam_y - dy;
          inten_next  = q_item.inten;
          draw_next   = (q_item.inten != 4'd0);
        end
        K_POSITION: begin
          scale_next  = q_item.scale;
          beam_x_next = {pos_x, 16'd0};
          beam_y_next = {pos_y, 16'd0};
        end
        K_HALT: halt_next = 1'b1;
        K_CALL: begin
          pc_next = q_item.target;
          if (full) begin
            halt_next  = 1'b1;
            level_next = '0;
          end else begin
            push       = 1'b1;
            level_next = level + 1'b1;
          end
        end
        K_RETURN: begin
          if (level != '0) begin
            level_next = level_dec;
            pc_next    = stack[level_dec[IDX_W-1:0]];
          end
        end
        K_JUMP: pc_next = q_item.target;
        default: pc_next = pc_step;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take && push) begin
      stack[level[IDX_W-1:0]] <= pc_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min <= '0;
      y_max <= {CFG_W{1'b1}};
    end else if (cfg_we) begin
      if (cfg_index == REG_X_MIN) begin
        x_min <= cfg_wdata;
      end else begin
        y_max <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      level     <= '0;
      scale     <= 4'd0;
      beam_x    <= '0;
      beam_y    <= '0;
      halt      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        pc        <= pc_next;
        level     <= level_next;
        scale     <= scale_next;
        beam_x    <= beam_x_next;
        beam_y    <= beam_y_next;
        halt      <= halt_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      next_address <= pc_next;
      draw         <= draw_next;
      start_x      <= sx_next;
      start_y      <= sy_next;
      end_x        <= beam_x_next[31:16];
      end_y        <= beam_y_next[31:16];
      intensity    <= inten_next;
      halted       <= halt_next;
    end
  end

endmodule

// ----- hw/rtl/vector_display_list_executor.sv -----
// Top level of the vector display-list executor: front end, queue, execution unit.
// Depends on vdl_pkg, vdl_front, vdl_queue and vdl_back.
//
//   channel   handshake             payload
//   input     in_valid / in_ready   command, first_word, second_word
//   result    out_valid / out_ready next_address, draw, start/end x/y, intensity, halted
//   config    cfg_we                cfg_index, cfg_wdata (10 bits)
//
// One item per cycle sustained while out_ready stays high; each item taken is written
// into the decode queue, and the execution unit then registers its result as it updates
// the address and beam state. rst is synchronous and clears queue, state and result valid.
// The queue holds two decoded items; in a sustained stream it absorbs one more item when
// the output stalls, then in_ready drops until the result is taken.
module vector_display_list_executor import vdl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [15:0]        first_word,
  input  logic [15:0]        second_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ADDR_W-1:0]  next_address,
  output logic               draw,
  output logic signed [15:0] start_x,
  output logic signed [15:0] start_y,
  output logic signed [15:0] end_x,
  output logic signed [15:0] end_y,
  output logic [3:0]         intensity,
  output logic               halted
);

  logic  dec_valid;
  logic  dec_ready;
  item_t dec_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  vdl_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .first_word  (first_word),
    .second_word (second_word),
    .dec_valid   (dec_valid),
    .dec_ready   (dec_ready),
    .dec_item    (dec_item)
  );

  vdl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (dec_valid),
    .wr_ready (dec_ready),
    .wr_item  (dec_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  vdl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .next_address (next_address),
    .draw         (draw),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .intensity    (intensity),
    .halted       (halted)
  );

endmodule

// ----- hw/rtl/vdl_checker.sv -----
// Port-level checks of the vector display-list executor, bound to the top level.
// Depends on vdl_pkg.
module vdl_checker import vdl_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [ADDR_W-1:0]  next_address,
  input logic               draw,
  input logic signed [15:0] start_x,
  input logic signed [15:0] start_y,
  input logic signed [15:0] end_x,
  input logic signed [15:0] end_y,
  input logic [3:0]         intensity,
  input logic               halted
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_address) && $stable(end_x))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_draw: assert property (@(posedge clk) disable iff (rst)
    out_valid && draw |-> intensity != 4'd0 && !halted)
    else $error("line drawn with beam off or while halted");

  a_halt_still: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted |-> start_x == end_x && start_y == end_y)
    else $error("beam moved on a halted result");

endmodule

bind vector_display_list_executor vdl_checker u_vdl_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .next_address (next_address),
  .draw         (draw),
  .start_x      (start_x),
  .start_y      (start_y),
  .end_x        (end_x),
  .end_y        (end_y),
  .intensity    (intensity),
  .halted       (halted)
);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of vector_display_list_executor: directed rows, then random
// instruction streams, checked against a built-in executor model. Uses vdl_pkg.
module tb;
  import vdl_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] next_address;
    logic              draw;
    logic [15:0]       start_x;
    logic [15:0]       start_y;
    logic [15:0]       end_x;
    logic [15:0]       end_y;
    logic [3:0]        intensity;
    logic              halted;
  } step_result_t;

  typedef struct {
    logic         cmd;
    logic [15:0]  w1;
    logic [15:0]  w2;
    bit           typed;
    step_result_t want;
  } dir_row_t;

  localparam step_result_t RES_CLEAR   = '0;
  localparam step_result_t RES_HALT_AT2 = '{next_address: 13'd2, halted: 1'b1, default: '0};
  localparam int PHASE_ITEMS = 260;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic               cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic               command;
  logic [15:0]        first_word;
  logic [15:0]        second_word;
  logic               out_valid;
  logic               out_ready;
  logic [ADDR_W-1:0]  next_address;
  logic               draw;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic [3:0]         intensity;
  logic               halted;

  vector_display_list_executor u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .first_word(first_word), .second_word(second_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_address(next_address), .draw(draw),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .intensity(intensity), .halted(halted)
  );

  // executor state
  logic [ADDR_W-1:0] vpc;
  logic [ADDR_W-1:0] vstack [STACK_DEPTH];
  int                vlevel;
  logic [3:0]        vscale;
  logic [31:0]       beam_x;
  logic [31:0]       beam_y;
  bit                vhalt;
  logic [9:0]        x_min;
  logic [9:0]        y_max;

  step_result_t predicted_steps [$];
  step_result_t got;
  step_result_t want;
  int           err_cnt = 0;
  dir_row_t     dir_rows [25];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [31:0] vec_delta(logic [9:0] m, bit neg, logic [3:0] code);
    int                 sh;
    logic signed [31:0] v;
    sh = (code > SHIFT_CODE_LAST) ? 10 : 9 - int'(code);
    v = {6'b0, m, 16'b0};
    if (neg) v = -v;
    return v >>> sh;
  endfunction

  function automatic step_result_t exec_instruction(logic cmd, logic [15:0] w1,
                                                    logic [15:0] w2);
    step_result_t      r;
    logic [3:0]        op;
    logic [3:0]        code;
    logic [3:0]        inten;
    logic [ADDR_W-1:0] nxt;
    logic [9:0]        mx;
    logic [9:0]        my;
    bit                nx;
    bit                ny;
    bit                vec;
    logic [31:0]       px;
    logic [31:0]       py;
    r = '0;
    r.start_x = beam_x[31:16];
    r.start_y = beam_y[31:16];
    inten = '0;
    vec = 0;
    code = '0;
    mx = '0; my = '0; nx = 0; ny = 0;
    if (cmd == CMD_START) begin
      vpc = '0;
      vlevel = 0;
      vscale = '0;
      beam_x = '0;
      beam_y = '0;
      vhalt = 0;
      r.start_x = '0;
      r.start_y = '0;
    end else if (!vhalt) begin
      op = w1[15:12];
      nxt = vpc + 13'd2;
      if (op <= OP_LONG_LAST) begin
        nxt = nxt + 13'd2;
        inten = w2[15:12];
        my = w1[9:0];
        ny = w1[10];
        mx = w2[9:0];
        nx = w2[10];
        code = vscale + op;
        vec = 1;
      end else begin
        case (op)
          OP_SHORT: begin
            inten = w1[7:4];
            my = {w1[9:8], 8'b0};
            ny = w1[10];
            mx = {w1[1:0], 8'b0};
            nx = w1[2];
            code = vscale + 4'd2 + {2'b0, w1[3], 1'b0} + {3'b0, w1[11]};
            vec = 1;
          end
          OP_POSITION: begin
            nxt = nxt + 13'd2;
            vscale = w2[15:12];
            px = {{20{w2[11]}}, w2[11:0]};
            py = {{20{w1[11]}}, w1[11:0]};
            beam_x = (px - {22'b0, x_min}) << 16;
            beam_y = ({22'b0, y_max} - py) << 16;
          end
          OP_HALT: vhalt = 1;
          OP_CALL: begin
            if (vlevel >= STACK_DEPTH) begin
              vhalt = 1;
              vlevel = 0;
            end else begin
              vstack[vlevel] = nxt;
              vlevel++;
            end
            nxt = {w1[11:0], 1'b0};
          end
          OP_RETURN: begin
            if (vlevel > 0) begin
              vlevel--;
              nxt = vstack[vlevel];
            end
          end
          default: nxt = {w1[11:0], 1'b0};
        endcase
      end
      if (vec) begin
        beam_x = beam_x + vec_delta(mx, nx, code);
        beam_y = beam_y - vec_delta(my, ny, code);
      end
      vpc = nxt;
    end
    r.next_address = vpc;
    r.draw = vec && (inten != 4'd0);
    r.end_x = beam_x[31:16];
    r.end_y = beam_y[31:16];
    r.intensity = inten;
    r.halted = vhalt;
    return r;
  endfunction

  task automatic send_item(input logic cmd, input logic [15:0] w1, input logic [15:0] w2,
                           input bit typed, input step_result_t fixed);
    step_result_t pred;
    in_valid = 1'b1;
    command = cmd;
    first_word = w1;
    second_word = w2;
    do @(posedge clk); while (in_ready !== 1'b1);
    pred = exec_instruction(cmd, w1, w2);
    predicted_steps.push_back(typed ? fixed : pred);
    @(negedge clk);
  endtask

  task automatic drain();
    while (predicted_steps.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [9:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_X_MIN) x_min = val;
    else y_max = val;
  endtask

  task automatic pick_instruction(output logic cmd, output logic [15:0] w1,
                                  output logic [15:0] w2);
    int r;
    cmd = CMD_EXEC;
    w1 = 16'($urandom);
    w2 = 16'($urandom);
    r = $urandom_range(0, 99);
    if (vhalt) begin
      if (r < 70) cmd = CMD_START;
    end else if (r < 2) cmd = CMD_START;
    else if (r < 40) w1[15:12] = 4'($urandom_range(0, OP_LONG_LAST));
    else if (r < 62) w1[15:12] = OP_SHORT;
    else if (r < 70) w1[15:12] = OP_POSITION;
    else if (r < 79) w1[15:12] = OP_CALL;
    else if (r < 88) w1[15:12] = OP_RETURN;
    else if (r < 93) w1[15:12] = OP_JUMP;
    else if (r < 96) w1[15:12] = OP_HALT;
    else cmd = 1'($urandom);
  endtask

  initial begin
    int mode, len, j;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(16, 160);
      for (j = 0; j < len; j++) begin
        @(negedge clk);
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = 1'($urandom);
          2: out_ready = ($urandom_range(0, 7) != 0);
          default: out_ready = ((j % 11) < 7);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got = '{next_address, draw, start_x, start_y, end_x, end_y, intensity, halted};
      if (predicted_steps.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("MISMATCH: unexpected result addr=%h draw=%b", got.next_address, got.draw);
      end else begin
        want = predicted_steps.pop_front();
        if (got.next_address !== want.next_address || got.draw !== want.draw ||
            got.start_x !== want.start_x || got.start_y !== want.start_y ||
            got.end_x !== want.end_x || got.end_y !== want.end_y ||
            got.intensity !== want.intensity || got.halted !== want.halted) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("MISMATCH: exp addr=%h draw=%b start=(%0d,%0d) end=(%0d,%0d) int=%0d halt=%b",
                     want.next_address, want.draw, $signed(want.start_x),
                     $signed(want.start_y), $signed(want.end_x), $signed(want.end_y),
                     want.intensity, want.halted);
            $display("          got addr=%h draw=%b start=(%0d,%0d) end=(%0d,%0d) int=%0d halt=%b",
                     got.next_address, got.draw, $signed(got.start_x),
                     $signed(got.start_y), $signed(got.end_x), $signed(got.end_y),
                     got.intensity, got.halted);
          end
        end
      end
    end
  end

  initial begin
    int          i, p, k, count, burst;
    logic        c;
    logic [15:0] a, b;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    command = CMD_START;
    first_word = '0;
    second_word = '0;
    vpc = '0;
    for (i = 0; i < STACK_DEPTH; i++) vstack[i] = '0;
    vlevel = 0;
    vscale = '0;
    beam_x = '0;
    beam_y = '0;
    vhalt = 0;
    x_min = 10'd0;
    y_max = 10'd1023;

    dir_rows = '{
      '{CMD_START, 16'h0000, 16'h0000, 1'b1, RES_CLEAR},
      '{CMD_EXEC,  16'hb000, 16'h0000, 1'b1, RES_HALT_AT2},
      '{CMD_EXEC,  16'h1234, 16'hffff, 1'b1, RES_HALT_AT2},
      '{CMD_START, 16'hffff, 16'hffff, 1'b1, RES_CLEAR},
      '{CMD_EXEC,  16'h07ff, 16'hf3ff, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'h93ff, 16'h07ff, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'ha800, 16'hf7ff, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'h0155, 16'h82aa, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'hffff, 16'h0000, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'hf000, 16'hffff, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'ha000, 16'h0000, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'hf37b, 16'h0000, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'hc100, 16'h0000, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'hcfff, 16'h0000, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'hc000, 16'h0000, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'hc010, 16'h0000, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'hc020, 16'h0000, 1'b0, RES_CLEAR},
      '{CMD_START, 16'h0000, 16'h0000, 1'b1, RES_CLEAR},
      '{CMD_EXEC,  16'hd000, 16'h0000, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'hc800, 16'h0000, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'hd000, 16'h0000, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'hefff, 16'h0000, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'h3000, 16'h5001, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'ha7ff, 16'h0800, 1'b0, RES_CLEAR},
      '{CMD_EXEC,  16'hbfff, 16'h0000, 1'b0, RES_CLEAR}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_reg(REG_X_MIN, 10'd0);
    write_reg(REG_Y_MAX, 10'd1023);

    for (i = 0; i < 25; i++) begin
      send_item(dir_rows[i].cmd, dir_rows[i].w1, dir_rows[i].w2,
                dir_rows[i].typed, dir_rows[i].want);
      if ($urandom_range(0, 3) == 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
    end
    in_valid = 1'b0;

    for (p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: begin
          write_reg(REG_X_MIN, 10'd1023);
          write_reg(REG_Y_MAX, 10'd0);
        end
        1: begin
          write_reg(REG_X_MIN, 10'd0);
          write_reg(REG_Y_MAX, 10'd0);
        end
        2: begin
          write_reg(REG_X_MIN, 10'd1023);
          write_reg(REG_Y_MAX, 10'd1023);
        end
        default: begin
          write_reg(REG_X_MIN, 10'($urandom));
          write_reg(REG_Y_MAX, 10'($urandom));
        end
      endcase
      count = 0;
      while (count < PHASE_ITEMS) begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 20);
        for (k = 0; k < burst && count < PHASE_ITEMS; k++) begin
          pick_instruction(c, a, b);
          if (!(vhalt && c == CMD_EXEC)) count++;
          send_item(c, a, b, 1'b0, RES_CLEAR);
        end
        in_valid = 1'b0;
        if ($urandom_range(0, 49) == 0) drain();
        else repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- vector_display_list_executor.f -----
hw/rtl/vdl_pkg.sv
hw/rtl/vdl_front.sv
hw/rtl/vdl_queue.sv
hw/rtl/vdl_back.sv
hw/rtl/vector_display_list_executor.sv
hw/rtl/vdl_checker.sv
tb/tb.sv
